>>> rtl/bale_pkg.sv
`default_nettype none
package bale_pkg;

    typedef enum logic [3:0] {
        ACT_DUMP    = 4'd0,
        ACT_READ    = 4'd1,
        ACT_UPDATE  = 4'd2,
        ACT_LSEARCH = 4'd3,
        ACT_INSERT  = 4'd4,
        ACT_DELETE  = 4'd5,
        ACT_DELNTH  = 4'd6,
        ACT_SORT    = 4'd7,
        ACT_MEMBER  = 4'd8
    } act_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_BAD_INDEX  = 3'd2,
        ST_FULL       = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_BAD_ACTION = 3'd5
    } status_t;

    typedef enum logic [2:0] {RA_I, RA_IP1, RA_IM1, RA_MID, RA_POS} raddr_t;
    typedef enum logic [0:0] {WA_I, WA_POS} waddr_t;
    typedef enum logic [1:0] {WD_RD, WD_VAL, WD_CUR} wdata_t;
    typedef enum logic [1:0] {BK_STORE, BK_COPY, BK_REG} bank_t;
    typedef enum logic [2:0] {IO_HOLD, IO_ZERO, IO_POS, IO_N, IO_NM1, IO_INC, IO_DEC} iop_t;
    typedef enum logic [1:0] {NO_HOLD, NO_INC, NO_DEC} nop_t;
    // For the bank register, set selects the scratch copy.
    typedef enum logic [1:0] {MK_HOLD, MK_SET, MK_CLR} mark_t;
    typedef enum logic [1:0] {LR_HOLD, LR_INIT, LR_UP, LR_DOWN} lrop_t;
    typedef enum logic [2:0] {RI_ZERO, RI_I, RI_HIT, RI_POS, RI_MID} ridx_t;
    typedef enum logic [1:0] {RV_ZERO, RV_VAL, RV_RD, RV_CUR} rval_t;

    typedef struct packed {
        logic    ready;
        logic    mem_rd;
        raddr_t  raddr;
        logic    mem_wr;
        waddr_t  waddr;
        wdata_t  wdata;
        bank_t   bank;
        iop_t    i_op;
        logic    e_load;
        logic    e_dec;
        logic    cur_load;
        logic    hit_load;
        logic    seen_clr;
        logic    seen_inc;
        nop_t    n_op;
        mark_t   sorted_op;
        mark_t   pend_op;
        mark_t   bank_op;
        lrop_t   lr_op;
        logic    res_load;
        status_t res_status;
        ridx_t   res_idx;
        rval_t   res_val;
        logic    res_last;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [3:0] act;
        logic       full;
        logic       pos_gt_n;
        logic       pos_ge_n;
        logic       empty;
        logic       occ_zero;
        logic       sorted;
        logic       i_zero;
        logic       i_eq_pos;
        logic       i_last;
        logic       i1_ge_n;
        logic       i1_eq_e;
        logic       e_one;
        logic       n_le1;
        logic       match;
        logic       seen_hit;
        logic       cur_gt_rd;
        logic       val_gt_rd;
        logic       lr_empty;
        logic       pend;
        logic       bank_copy;
        logic       out_space;
    } sts_t;

endpackage
`default_nettype wire

>>> rtl/bale_ifs.sv
`default_nettype none
interface bale_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         action;
    logic [6:0]         position;
    logic signed [31:0] operand_value;
    logic [6:0]         occurrence;
    modport source (output valid, action, position, operand_value, occurrence, input ready);
    modport sink (input valid, action, position, operand_value, occurrence, output ready);
endinterface

interface bale_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [5:0]         result_index;
    logic signed [31:0] result_value;
    logic [6:0]         list_length;
    logic               last;
    modport source (output valid, status, result_index, result_value, list_length, last,
                    input ready);
    modport sink (input valid, status, result_index, result_value, list_length, last,
                  output ready);
endinterface

interface bale_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/bale_ctrl.sv
`default_nettype none
module bale_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  bale_pkg::sts_t  sts,
    output bale_pkg::cmd_t  cmd
);
    import bale_pkg::*;

    typedef enum logic [32:0] {
        S_IDLE      = 33'd1 << 0,
        S_DISPATCH  = 33'd1 << 1,
        S_EMIT      = 33'd1 << 2,
        S_SHUP_RD   = 33'd1 << 3,
        S_SHUP_WR   = 33'd1 << 4,
        S_INS_WR    = 33'd1 << 5,
        S_DUMP_RD   = 33'd1 << 6,
        S_DUMP_SET  = 33'd1 << 7,
        S_RD_RD     = 33'd1 << 8,
        S_RD_SET    = 33'd1 << 9,
        S_UPD_WR    = 33'd1 << 10,
        S_DEL_RD0   = 33'd1 << 11,
        S_DEL_CAP   = 33'd1 << 12,
        S_DEL_RD    = 33'd1 << 13,
        S_DEL_WR    = 33'd1 << 14,
        S_DEL_END   = 33'd1 << 15,
        S_LS_RD     = 33'd1 << 16,
        S_LS_CMP    = 33'd1 << 17,
        S_LS_HIT    = 33'd1 << 18,
        S_LS_END    = 33'd1 << 19,
        S_ND_RD     = 33'd1 << 20,
        S_ND_CMP    = 33'd1 << 21,
        S_SORT_INIT = 33'd1 << 22,
        S_PASS_RD   = 33'd1 << 23,
        S_PASS_CAP  = 33'd1 << 24,
        S_SB_RD     = 33'd1 << 25,
        S_SB_CMP    = 33'd1 << 26,
        S_SB_TAIL   = 33'd1 << 27,
        S_SORT_DONE = 33'd1 << 28,
        S_CP_RD     = 33'd1 << 29,
        S_CP_WR     = 33'd1 << 30,
        S_BS_TEST   = 33'd1 << 31,
        S_BS_CMP    = 33'd1 << 32
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (sts.in_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                // Most branches end in a single final beat.
                cmd.res_last = 1'b1;
                ret_next     = S_IDLE;
                if (sts.act > ACT_MEMBER)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_BAD_ACTION;
                    state_next     = S_EMIT;
                end
                else if (sts.act == ACT_INSERT)
                begin
                    if (sts.full || sts.pos_gt_n)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = sts.full ? ST_FULL : ST_BAD_INDEX;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        cmd.i_op   = IO_N;
                        state_next = S_SHUP_RD;
                    end
                end
                else if (sts.empty)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_EMPTY;
                    state_next     = S_EMIT;
                end
                else
                begin
                    unique case (act_t'(sts.act))
                        ACT_DUMP:
                        begin
                            cmd.i_op   = IO_ZERO;
                            state_next = S_DUMP_RD;
                        end
                        ACT_READ, ACT_UPDATE, ACT_DELETE:
                        begin
                            if (sts.pos_ge_n)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_BAD_INDEX;
                                state_next     = S_EMIT;
                            end
                            else if (sts.act == ACT_READ)
                                state_next = S_RD_RD;
                            else if (sts.act == ACT_UPDATE)
                                state_next = S_UPD_WR;
                            else
                            begin
                                cmd.i_op   = IO_POS;
                                state_next = S_DEL_RD0;
                            end
                        end
                        ACT_LSEARCH:
                        begin
                            cmd.i_op    = IO_ZERO;
                            cmd.pend_op = MK_CLR;
                            state_next  = S_LS_RD;
                        end
                        ACT_DELNTH:
                        begin
                            if (sts.occ_zero)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_OK;
                                state_next     = S_EMIT;
                            end
                            else
                            begin
                                cmd.i_op     = IO_NM1;
                                cmd.seen_clr = 1'b1;
                                state_next   = S_ND_RD;
                            end
                        end
                        ACT_SORT:
                        begin
                            cmd.bank_op = MK_CLR;
                            state_next  = S_SORT_INIT;
                        end
                        ACT_MEMBER:
                        begin
                            if (sts.sorted)
                            begin
                                cmd.bank_op = MK_CLR;
                                cmd.lr_op   = LR_INIT;
                                state_next  = S_BS_TEST;
                            end
                            else
                            begin
                                cmd.i_op   = IO_ZERO;
                                state_next = S_CP_RD;
                            end
                        end
                        default:
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_BAD_ACTION;
                            state_next     = S_EMIT;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (sts.out_space)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ret_reg;
                end
            end
            S_SHUP_RD:
            begin
                if (sts.i_eq_pos)
                    state_next = S_INS_WR;
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.raddr  = RA_IM1;
                    cmd.bank   = BK_STORE;
                    state_next = S_SHUP_WR;
                end
            end
            S_SHUP_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.waddr  = WA_I;
                cmd.wdata  = WD_RD;
                cmd.bank   = BK_STORE;
                cmd.i_op   = IO_DEC;
                state_next = S_SHUP_RD;
            end
            S_INS_WR:
            begin
                cmd.mem_wr     = 1'b1;
                cmd.waddr      = WA_POS;
                cmd.wdata      = WD_VAL;
                cmd.bank       = BK_STORE;
                cmd.n_op       = NO_INC;
                cmd.sorted_op  = MK_CLR;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_idx    = RI_POS;
                cmd.res_val    = RV_VAL;
                cmd.res_last   = 1'b1;
                ret_next       = S_IDLE;
                state_next     = S_EMIT;
            end
            S_DUMP_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.raddr  = RA_I;
                cmd.bank   = BK_STORE;
                state_next = S_DUMP_SET;
            end
            S_DUMP_SET:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_idx    = RI_I;
                cmd.res_val    = RV_RD;
                cmd.res_last   = sts.i_last;
                cmd.i_op       = IO_INC;
                ret_next       = sts.i_last ? S_IDLE : S_DUMP_RD;
                state_next     = S_EMIT;
            end
            S_RD_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.raddr  = RA_POS;
                cmd.bank   = BK_STORE;
                state_next = S_RD_SET;
            end
            S_RD_SET:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_idx    = RI_POS;
                cmd.res_val    = RV_RD;
                cmd.res_last   = 1'b1;
                ret_next       = S_IDLE;
                state_next     = S_EMIT;
            end
            S_UPD_WR:
            begin
                cmd.mem_wr     = 1'b1;
                cmd.waddr      = WA_POS;
                cmd.wdata      = WD_VAL;
                cmd.bank       = BK_STORE;
                cmd.sorted_op  = MK_CLR;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_idx    = RI_POS;
                cmd.res_val    = RV_VAL;
                cmd.res_last   = 1'b1;
                ret_next       = S_IDLE;
                state_next     = S_EMIT;
            end
            S_DEL_RD0:
            begin
                cmd.mem_rd = 1'b1;
                cmd.raddr  = RA_I;
                cmd.bank   = BK_STORE;
                state_next = S_DEL_CAP;
            end
            S_DEL_CAP:
            begin
                cmd.cur_load = 1'b1;
                cmd.hit_load = 1'b1;
                state_next   = S_DEL_RD;
            end
            S_DEL_RD:
            begin
                if (sts.i1_ge_n)
                    state_next = S_DEL_END;
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.raddr  = RA_IP1;
                    cmd.bank   = BK_STORE;
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.waddr  = WA_I;
                cmd.wdata  = WD_RD;
                cmd.bank   = BK_STORE;
                cmd.i_op   = IO_INC;
                state_next = S_DEL_RD;
            end
            S_DEL_END:
            begin
                cmd.n_op       = NO_DEC;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_idx    = RI_HIT;
                cmd.res_val    = RV_CUR;
                cmd.res_last   = 1'b1;
                ret_next       = S_IDLE;
                state_next     = S_EMIT;
            end
            S_LS_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.raddr  = RA_I;
                cmd.bank   = BK_STORE;
                state_next = S_LS_CMP;
            end
            S_LS_CMP, S_LS_HIT:
            begin
                // A match is held back one step so that the final beat can carry last.
                if (state_reg == S_LS_CMP && sts.match && sts.pend)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_idx    = RI_HIT;
                    cmd.res_val    = RV_VAL;
                    ret_next       = S_LS_HIT;
                    state_next     = S_EMIT;
                end
                else
                begin
                    if (state_reg == S_LS_HIT || sts.match)
                    begin
                        cmd.hit_load = 1'b1;
                        cmd.pend_op  = MK_SET;
                    end
                    if (sts.i_last)
                        state_next = S_LS_END;
                    else
                    begin
                        cmd.i_op   = IO_INC;
                        state_next = S_LS_RD;
                    end
                end
            end
            S_LS_END:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = sts.pend ? ST_OK : ST_NOT_FOUND;
                cmd.res_idx    = sts.pend ? RI_HIT : RI_ZERO;
                cmd.res_val    = sts.pend ? RV_VAL : RV_ZERO;
                cmd.res_last   = 1'b1;
                ret_next       = S_IDLE;
                state_next     = S_EMIT;
            end
            S_ND_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.raddr  = RA_I;
                cmd.bank   = BK_STORE;
                state_next = S_ND_CMP;
            end
            S_ND_CMP:
            begin
                cmd.seen_inc = sts.match;
                if (sts.match && sts.seen_hit)
                    state_next = S_DEL_CAP;
                else if (sts.i_zero)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    cmd.res_last   = 1'b1;
                    ret_next       = S_IDLE;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cmd.i_op   = IO_DEC;
                    state_next = S_ND_RD;
                end
            end
            S_SORT_INIT:
            begin
                cmd.i_op   = IO_ZERO;
                cmd.e_load = 1'b1;
                state_next = sts.n_le1 ? S_SORT_DONE : S_PASS_RD;
            end
            S_PASS_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.raddr  = RA_I;
                cmd.bank   = BK_REG;
                state_next = S_PASS_CAP;
            end
            S_PASS_CAP:
            begin
                cmd.cur_load = 1'b1;
                state_next   = S_SB_RD;
            end
            S_SB_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.raddr  = RA_IP1;
                cmd.bank   = BK_REG;
                state_next = S_SB_CMP;
            end
            S_SB_CMP:
            begin
                // The larger value rides along; the smaller one settles at i.
                cmd.mem_wr   = 1'b1;
                cmd.waddr    = WA_I;
                cmd.wdata    = sts.cur_gt_rd ? WD_RD : WD_CUR;
                cmd.bank     = BK_REG;
                cmd.cur_load = !sts.cur_gt_rd;
                cmd.i_op     = IO_INC;
                state_next   = sts.i1_eq_e ? S_SB_TAIL : S_SB_RD;
            end
            S_SB_TAIL:
            begin
                cmd.mem_wr = 1'b1;
                cmd.waddr  = WA_I;
                cmd.wdata  = WD_CUR;
                cmd.bank   = BK_REG;
                cmd.e_dec  = 1'b1;
                cmd.i_op   = IO_ZERO;
                state_next = sts.e_one ? S_SORT_DONE : S_PASS_RD;
            end
            S_SORT_DONE:
            begin
                if (sts.bank_copy)
                begin
                    cmd.lr_op  = LR_INIT;
                    state_next = S_BS_TEST;
                end
                else
                begin
                    cmd.sorted_op  = MK_SET;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_last   = 1'b1;
                    ret_next       = S_IDLE;
                    state_next     = S_EMIT;
                end
            end
            S_CP_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.raddr  = RA_I;
                cmd.bank   = BK_STORE;
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.waddr  = WA_I;
                cmd.wdata  = WD_RD;
                cmd.bank   = BK_COPY;
                if (sts.i_last)
                begin
                    cmd.bank_op = MK_SET;
                    state_next  = S_SORT_INIT;
                end
                else
                begin
                    cmd.i_op   = IO_INC;
                    state_next = S_CP_RD;
                end
            end
            S_BS_TEST:
            begin
                if (sts.lr_empty)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    cmd.res_last   = 1'b1;
                    ret_next       = S_IDLE;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.raddr  = RA_MID;
                    cmd.bank   = BK_REG;
                    state_next = S_BS_CMP;
                end
            end
            S_BS_CMP:
            begin
                if (sts.match)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_idx    = RI_MID;
                    cmd.res_val    = RV_VAL;
                    cmd.res_last   = 1'b1;
                    ret_next       = S_IDLE;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cmd.lr_op  = sts.val_gt_rd ? LR_UP : LR_DOWN;
                    state_next = S_BS_TEST;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/bale_dpath.sv
`default_nettype none
module bale_dpath #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    bale_req_if.sink        req,
    bale_rsp_if.source      rsp,
    bale_cfg_if.sink        cfg,
    input  bale_pkg::cmd_t  cmd,
    output bale_pkg::sts_t  sts
);
    import bale_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 7;
    localparam int DW = DATA_WIDTH;

    // Lower half holds the list, upper half the scratch copy used by member search.
    logic [DW-1:0] mem [2**(IW+1)];
    logic signed [DW-1:0] rd_reg;

    logic [3:0]  act_reg;
    logic [6:0]  pos_reg;
    logic [6:0]  occ_reg;
    logic signed [DW-1:0] val_reg;
    logic [6:0]  limit_reg;
    logic [CW-1:0] n_reg, i_reg, e_reg, hit_reg;
    logic signed [DW-1:0] cur_reg;
    logic [6:0]  seen_reg;
    logic        sorted_reg, pend_reg, bank_reg;
    logic signed [CW:0] l_reg, r_reg;

    logic [2:0]  res_status_reg;
    logic [5:0]  res_idx_reg;
    logic [31:0] res_val_reg;
    logic        res_last_reg;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [5:0]  out_idx_reg;
    logic [31:0] out_val_reg;
    logic [6:0]  out_len_reg;
    logic        out_last_reg;

    logic signed [DW+31:0] op_ext;
    logic signed [CW+1:0]  lr_sum;
    logic signed [CW:0]    mid;
    logic [CW:0]           i_p1;
    logic [CW-1:0]         pos_cw;
    logic [CW-1:0]         ra_idx, wa_idx;
    logic                  bank_bit;
    logic [DW-1:0]         wdata;
    logic [CW:0]           idx_src;
    logic signed [DW-1:0]  val_src;
    logic signed [DW+31:0] val_ext;
    logic [XW-1:0]         len_ext, idx_ext;

    assign op_ext = (DW + 32)'(req.operand_value);
    assign lr_sum = {l_reg[CW], l_reg} + {r_reg[CW], r_reg};
    assign mid    = lr_sum[CW+1:1];
    assign i_p1   = {1'b0, i_reg} + (CW + 1)'(1);
    assign pos_cw = CW'(XW'(pos_reg));

    always_comb
    begin
        case (cmd.raddr)
            RA_I:    ra_idx = i_reg;
            RA_IP1:  ra_idx = i_p1[CW-1:0];
            RA_IM1:  ra_idx = i_reg - CW'(1);
            RA_MID:  ra_idx = mid[CW-1:0];
            RA_POS:  ra_idx = pos_cw;
            default: ra_idx = i_reg;
        endcase
        wa_idx = (cmd.waddr == WA_POS) ? pos_cw : i_reg;
        case (cmd.bank)
            BK_STORE: bank_bit = 1'b0;
            BK_COPY:  bank_bit = 1'b1;
            default:  bank_bit = bank_reg;
        endcase
        case (cmd.wdata)
            WD_VAL:  wdata = val_reg;
            WD_CUR:  wdata = cur_reg;
            default: wdata = rd_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[{bank_bit, wa_idx[IW-1:0]}] <= wdata;
        if (cmd.mem_rd)
            rd_reg <= mem[{bank_bit, ra_idx[IW-1:0]}];
    end

    // Input beat and scan registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            act_reg <= req.action;
            pos_reg <= req.position;
            occ_reg <= req.occurrence;
            val_reg <= op_ext[DW-1:0];
        end
        case (cmd.i_op)
            IO_ZERO: i_reg <= '0;
            IO_POS:  i_reg <= pos_cw;
            IO_N:    i_reg <= n_reg;
            IO_NM1:  i_reg <= n_reg - CW'(1);
            IO_INC:  i_reg <= i_p1[CW-1:0];
            IO_DEC:  i_reg <= i_reg - CW'(1);
            default: i_reg <= i_reg;
        endcase
        if (cmd.e_load)
            e_reg <= n_reg - CW'(1);
        else if (cmd.e_dec)
            e_reg <= e_reg - CW'(1);
        if (cmd.cur_load)
            cur_reg <= rd_reg;
        if (cmd.hit_load)
            hit_reg <= i_reg;
        if (cmd.seen_clr)
            seen_reg <= '0;
        else if (cmd.seen_inc)
            seen_reg <= seen_reg + 7'd1;
        if (cmd.pend_op == MK_SET)
            pend_reg <= 1'b1;
        else if (cmd.pend_op == MK_CLR)
            pend_reg <= 1'b0;
        if (cmd.bank_op == MK_SET)
            bank_reg <= 1'b1;
        else if (cmd.bank_op == MK_CLR)
            bank_reg <= 1'b0;
        case (cmd.lr_op)
            LR_INIT:
            begin
                l_reg <= '0;
                r_reg <= $signed({1'b0, n_reg}) - (CW + 1)'(1);
            end
            LR_UP:   l_reg <= mid + (CW + 1)'(1);
            LR_DOWN: r_reg <= mid - (CW + 1)'(1);
            default: l_reg <= l_reg;
        endcase
    end

    // Result fields are staged before the emit state hands them to the output register.
    always_comb
    begin
        case (cmd.res_idx)
            RI_I:    idx_src = {1'b0, i_reg};
            RI_HIT:  idx_src = {1'b0, hit_reg};
            RI_POS:  idx_src = (CW + 1)'(XW'(pos_reg));
            RI_MID:  idx_src = mid;
            default: idx_src = '0;
        endcase
        case (cmd.res_val)
            RV_VAL:  val_src = val_reg;
            RV_RD:   val_src = rd_reg;
            RV_CUR:  val_src = cur_reg;
            default: val_src = '0;
        endcase
        val_ext = (DW + 32)'(val_src);
        idx_ext = XW'(idx_src);
        len_ext = XW'(n_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_idx_reg    <= idx_ext[5:0];
            res_val_reg    <= val_ext[31:0];
            res_last_reg   <= cmd.res_last;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_idx_reg    <= res_idx_reg;
            out_val_reg    <= res_val_reg;
            out_len_reg    <= len_ext[6:0];
            out_last_reg   <= res_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            sorted_reg    <= 1'b0;
            limit_reg     <= 7'd64;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.n_op == NO_INC)
                n_reg <= n_reg + CW'(1);
            else if (cmd.n_op == NO_DEC)
                n_reg <= n_reg - CW'(1);
            if (cmd.sorted_op == MK_SET)
                sorted_reg <= 1'b1;
            else if (cmd.sorted_op == MK_CLR)
                sorted_reg <= 1'b0;
            if (cfg.valid)
                limit_reg <= cfg.data;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign req.ready = cmd.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.result_index  = out_idx_reg;
    assign rsp.result_value  = out_val_reg;
    assign rsp.list_length   = out_len_reg;
    assign rsp.last          = out_last_reg;

    always_comb
    begin
        sts.in_valid  = req.valid;
        sts.act       = act_reg;
        sts.full      = (XW'(n_reg) >= XW'(limit_reg)) || (XW'(n_reg) >= XW'(CAPACITY));
        sts.pos_gt_n  = XW'(pos_reg) > XW'(n_reg);
        sts.pos_ge_n  = XW'(pos_reg) >= XW'(n_reg);
        sts.empty     = (n_reg == '0);
        sts.occ_zero  = (occ_reg == '0);
        sts.sorted    = sorted_reg;
        sts.i_zero    = (i_reg == '0);
        sts.i_eq_pos  = XW'(i_reg) == XW'(pos_reg);
        sts.i_last    = (i_p1 == {1'b0, n_reg});
        sts.i1_ge_n   = (i_p1 >= {1'b0, n_reg});
        sts.i1_eq_e   = (i_p1 == {1'b0, e_reg});
        sts.e_one     = (e_reg == CW'(1));
        sts.n_le1     = (n_reg <= CW'(1));
        sts.match     = (rd_reg == val_reg);
        sts.seen_hit  = ({1'b0, seen_reg} + 8'd1) == {1'b0, occ_reg};
        sts.cur_gt_rd = cur_reg > rd_reg;
        sts.val_gt_rd = val_reg > rd_reg;
        sts.lr_empty  = l_reg > r_reg;
        sts.pend      = pend_reg;
        sts.bank_copy = bank_reg;
        sts.out_space = !out_valid_reg || rsp.ready;
    end
endmodule
`default_nettype wire

>>> rtl/bounded_array_list_engine.sv
// Channel  Kind         Carries
// req      stream in    action, position, operand_value, occurrence
// rsp      stream out   status, result_index, result_value, list_length, last
// cfg      write in     list_limit, always ready
//
// One item at a time; every step goes through the single-port element memory. Insert
// and delete shift the elements from pos on, dump and the scans walk the list, sort is a
// bubble sort, and member search on an unsorted list first copies the list to the scratch
// half and sorts the copy; member search then halves the sorted range to find the value.
// Reset empties the list, clears the sorted mark and sets the limit to 64; no clearing pass.
// A beat waits in the output register while the next item is taken; rsp stalls hold the
// engine only when a further beat is ready to go.
`default_nettype none
module bounded_array_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    bale_req_if.sink    req,
    bale_rsp_if.source  rsp,
    bale_cfg_if.sink    cfg
);
    import bale_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bale_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    bale_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );
endmodule
`default_nettype wire
